### rtl/sbe_pkg.sv
// Shared types and constants of the stack bytecode executor.
// Holds opcode codes, compare modes, sequencer states and status structs.
// No dependencies; all other files but the port checker refer to it.
`default_nettype none

package sbe_pkg;

  localparam int WORD_W = 16;
  localparam int BANK_W = 8;

  // Opcode numbering of the instruction set.
  typedef enum logic [4:0] {
    OP_END          = 5'd0,
    OP_PUSH         = 5'd1,
    OP_POP          = 5'd2,
    OP_CALL_REL     = 5'd3,
    OP_CALL         = 5'd4,
    OP_RET          = 5'd5,
    OP_LOOP_REL     = 5'd6,
    OP_LOOP         = 5'd7,
    OP_JUMP_REL     = 5'd8,
    OP_JUMP         = 5'd9,
    OP_CALL_FAR     = 5'd10,
    OP_RET_FAR      = 5'd11,
    OP_SYSTIME      = 5'd12,
    OP_INVOKE       = 5'd13,
    OP_BEGIN_THREAD = 5'd14,
    OP_IFCOND       = 5'd15,
    OP_DEBUG        = 5'd16,
    OP_PUSH_VALUE   = 5'd17,
    OP_RESERVE      = 5'd18,
    OP_SET          = 5'd19,
    OP_SET_CONST    = 5'd20,
    OP_START        = 5'd21
  } opcode_t;

  // Compare modes of the conditional branch.
  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_LT = 3'd1;
  localparam logic [2:0] CMP_GT = 3'd2;
  localparam logic [2:0] CMP_LE = 3'd3;
  localparam logic [2:0] CMP_GE = 3'd4;

  // Execute sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WR2
  } exec_state_t;

  // Bounds results of the two index operands.
  typedef struct packed {
    logic ia_ok;
    logic ib_ok;
  } slot_flags_t;

  // Program context kept across instructions.
  typedef struct packed {
    logic [WORD_W-1:0] pc;
    logic [BANK_W-1:0] bank;
    logic              run;
  } ctx_t;

  // Per-instruction status returned with each result word.
  typedef struct packed {
    logic              fault;
    logic [WORD_W-1:0] popped;
  } status_t;

  // Argument length in bytes that follows each opcode.
  function automatic logic [2:0] arg_len(input opcode_t op);
    logic [2:0] len;
    case (op)
      OP_PUSH:         len = 3'd2;
      OP_POP:          len = 3'd1;
      OP_CALL_REL:     len = 3'd1;
      OP_CALL:         len = 3'd2;
      OP_LOOP_REL:     len = 3'd1;
      OP_LOOP:         len = 3'd2;
      OP_JUMP_REL:     len = 3'd1;
      OP_JUMP:         len = 3'd2;
      OP_CALL_FAR:     len = 3'd3;
      OP_INVOKE:       len = 3'd4;
      OP_BEGIN_THREAD: len = 3'd3;
      OP_IFCOND:       len = 3'd6;
      OP_DEBUG:        len = 3'd2;
      OP_PUSH_VALUE:   len = 3'd1;
      OP_RESERVE:      len = 3'd1;
      OP_SET:          len = 3'd2;
      OP_SET_CONST:    len = 3'd3;
      default:         len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### rtl/stack_bytecode_executor.sv
// Top level of the stack bytecode executor: handshakes, item buffer,
// execute sequencer, program context and the result register.
// Depends on sbe_pkg, sbe_issue, sbe_exec and sbe_stack_mem.
//
//   Channel   Direction  Handshake          Contents
//   in_*      input      in_valid/in_stall  one decoded instruction word
//   out_*     output     out_valid/out_stall  context and status after it
//
// An instruction reads the stack memory, then executes and writes back.
// A far call, which pushes two words through the single write port, then
// writes its second word. The stack memory's one write port and the pointer
// dependency between instructions hold each issue until the last is done.
// Reset is synchronous and empties the stack through per-entry valid bits.
// A free item buffer takes a word while an earlier one executes or waits.
`default_nettype none

module stack_bytecode_executor #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [4:0]                             in_opcode,
  input  wire logic [15:0]                            in_immediate,
  input  wire logic [15:0]                            in_target_address,
  input  wire logic signed [7:0]                      in_offset,
  input  wire logic signed [7:0]                      in_index_a,
  input  wire logic signed [7:0]                      in_index_b,
  input  wire logic [2:0]                             in_compare_mode,
  input  wire logic [7:0]                             in_drop_count,
  input  wire logic [7:0]                             in_bank_value,
  input  wire logic [15:0]                            in_time_now,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [15:0]                                 out_program_counter,
  output logic [7:0]                                  out_code_bank,
  output logic [$clog2(STACK_DEPTH+1)-1:0]            out_stack_level,
  output logic [15:0]                                 out_popped_word,
  output logic                                        out_running,
  output logic                                        out_fault
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);

  // Item buffer.
  logic                   q_valid_r;
  logic                   q_valid_nxt;
  sbe_pkg::opcode_t       q_op_r;
  logic [15:0]            q_imm_r;
  logic [15:0]            q_tgt_r;
  logic signed [7:0]      q_ofs_r;
  logic signed [7:0]      q_ia_r;
  logic signed [7:0]      q_ib_r;
  logic [2:0]             q_mode_r;
  logic [7:0]             q_drop_r;
  logic [7:0]             q_bank_r;
  logic [15:0]            q_now_r;

  // Execute stage operands.
  sbe_pkg::opcode_t       e_op_r;
  logic [15:0]            e_imm_r;
  logic [15:0]            e_tgt_r;
  logic signed [7:0]      e_ofs_r;
  logic [2:0]             e_mode_r;
  logic [7:0]             e_drop_r;
  logic [7:0]             e_bank_r;
  logic [15:0]            e_now_r;
  logic [AW-1:0]          e_slot_ia_r;
  sbe_pkg::slot_flags_t   e_flags_r;

  // Architectural state and sequencer.
  sbe_pkg::ctx_t          ctx_r;
  logic [SPW-1:0]         sp_r;
  sbe_pkg::exec_state_t   state_r;
  sbe_pkg::exec_state_t   state_nxt;
  logic [AW-1:0]          wr2_addr_r;
  logic [15:0]            wr2_data_r;

  // Result register.
  logic                   out_valid_r;

  logic                   in_accept;
  logic                   issue_go;
  logic                   out_free;
  logic                   exec_done;

  logic [AW-1:0]          rd_addr_a;
  logic [AW-1:0]          rd_addr_b;
  logic [AW-1:0]          slot_ia;
  sbe_pkg::slot_flags_t   flags;
  logic [15:0]            rd_data_a;
  logic [15:0]            rd_data_b;

  sbe_pkg::ctx_t          ctx_nxt;
  logic [SPW-1:0]         sp_nxt;
  sbe_pkg::status_t       status;
  logic                   ex_wr_en;
  logic [AW-1:0]          ex_wr_addr;
  logic [15:0]            ex_wr_data;
  logic                   ex_wr2_en;
  logic [AW-1:0]          ex_wr2_addr;
  logic [15:0]            ex_wr2_data;

  logic                   mem_wr_en;
  logic [AW-1:0]          mem_wr_addr;
  logic [15:0]            mem_wr_data;

  // Handshake and pipeline control. Reads issue only when the execute stage
  // and the second push write are done, so every read sees the latest stack.
  assign out_free  = !out_valid_r || !out_stall;
  assign issue_go  = q_valid_r && (state_r == sbe_pkg::ST_IDLE);
  assign exec_done = (state_r == sbe_pkg::ST_EXEC) && out_free;
  assign in_stall  = q_valid_r && !issue_go;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    q_valid_nxt = q_valid_r;
    if (in_accept) begin
      q_valid_nxt = 1'b1;
    end else if (issue_go) begin
      q_valid_nxt = 1'b0;
    end
  end

  // Item buffer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else begin
      q_valid_r <= q_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      q_op_r   <= sbe_pkg::opcode_t'(in_opcode);
      q_imm_r  <= in_immediate;
      q_tgt_r  <= in_target_address;
      q_ofs_r  <= in_offset;
      q_ia_r   <= in_index_a;
      q_ib_r   <= in_index_b;
      q_mode_r <= in_compare_mode;
      q_drop_r <= in_drop_count;
      q_bank_r <= in_bank_value;
      q_now_r  <= in_time_now;
    end
  end

  // Slot resolution and read addresses from the current pointer.
  sbe_issue #(
    .STACK_DEPTH(STACK_DEPTH),
    .SPW        (SPW),
    .AW         (AW)
  ) u_issue (
    .op        (q_op_r),
    .index_a   (q_ia_r),
    .index_b   (q_ib_r),
    .drop_count(q_drop_r),
    .sp        (sp_r),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .slot_ia   (slot_ia),
    .flags     (flags)
  );

  // Execute stage operand registers.
  always_ff @(posedge clk) begin
    if (issue_go) begin
      e_op_r      <= q_op_r;
      e_imm_r     <= q_imm_r;
      e_tgt_r     <= q_tgt_r;
      e_ofs_r     <= q_ofs_r;
      e_mode_r    <= q_mode_r;
      e_drop_r    <= q_drop_r;
      e_bank_r    <= q_bank_r;
      e_now_r     <= q_now_r;
      e_slot_ia_r <= slot_ia;
      e_flags_r   <= flags;
    end
  end

  sbe_exec #(
    .STACK_DEPTH(STACK_DEPTH),
    .SPW        (SPW),
    .AW         (AW)
  ) u_exec (
    .op            (e_op_r),
    .immediate     (e_imm_r),
    .target_address(e_tgt_r),
    .offset        (e_ofs_r),
    .compare_mode  (e_mode_r),
    .drop_count    (e_drop_r),
    .bank_value    (e_bank_r),
    .time_now      (e_now_r),
    .slot_ia       (e_slot_ia_r),
    .flags         (e_flags_r),
    .rd_a          (rd_data_a),
    .rd_b          (rd_data_b),
    .ctx           (ctx_r),
    .sp            (sp_r),
    .ctx_nxt       (ctx_nxt),
    .sp_nxt        (sp_nxt),
    .status        (status),
    .wr_en         (ex_wr_en),
    .wr_addr       (ex_wr_addr),
    .wr_data       (ex_wr_data),
    .wr2_en        (ex_wr2_en),
    .wr2_addr      (ex_wr2_addr),
    .wr2_data      (ex_wr2_data)
  );

  // Write port: execute write-back, or the second word of a far call.
  always_comb begin
    mem_wr_en   = exec_done && ex_wr_en;
    mem_wr_addr = ex_wr_addr;
    mem_wr_data = ex_wr_data;
    if (state_r == sbe_pkg::ST_WR2) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = wr2_addr_r;
      mem_wr_data = wr2_data_r;
    end
  end

  sbe_stack_mem #(
    .DEPTH(STACK_DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (issue_go),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b),
    .rd_data_a(rd_data_a),
    .rd_data_b(rd_data_b),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_data  (mem_wr_data)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sbe_pkg::ST_IDLE: begin
        if (issue_go) begin
          state_nxt = sbe_pkg::ST_EXEC;
        end
      end
      sbe_pkg::ST_EXEC: begin
        if (out_free) begin
          state_nxt = ex_wr2_en ? sbe_pkg::ST_WR2 : sbe_pkg::ST_IDLE;
        end
      end
      sbe_pkg::ST_WR2: state_nxt = sbe_pkg::ST_IDLE;
      default:         state_nxt = sbe_pkg::ST_IDLE;
    endcase
  end

  // Program context and stack pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '0;
      sp_r  <= '0;
    end else if (exec_done) begin
      ctx_r <= ctx_nxt;
      sp_r  <= sp_nxt;
    end
  end

  // Pending second push word.
  always_ff @(posedge clk) begin
    if (exec_done) begin
      wr2_addr_r <= ex_wr2_addr;
      wr2_data_r <= ex_wr2_data;
    end
  end

  // Result register: loads on completion, holds while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      out_program_counter <= ctx_nxt.pc;
      out_code_bank       <= ctx_nxt.bank;
      out_running         <= ctx_nxt.run;
      out_stack_level     <= sp_nxt;
      out_popped_word     <= status.popped;
      out_fault           <= status.fault;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### rtl/sbe_stack_mem.sv
// Word stack storage: one write port, two registered read ports.
// Per-entry valid bits make never-written entries read as zero after reset.
// Depends on sbe_pkg for the word width.
`default_nettype none

module sbe_stack_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      rd_en,
  input  wire logic [AW-1:0]             rd_addr_a,
  input  wire logic [AW-1:0]             rd_addr_b,
  output logic [sbe_pkg::WORD_W-1:0]     rd_data_a,
  output logic [sbe_pkg::WORD_W-1:0]     rd_data_b,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [sbe_pkg::WORD_W-1:0] wr_data
);

  logic [sbe_pkg::WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           valid_r;
  logic [sbe_pkg::WORD_W-1:0] data_a_r;
  logic [sbe_pkg::WORD_W-1:0] data_b_r;
  logic                       vld_a_r;
  logic                       vld_b_r;

  // Storage array write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits are cleared by reset and set by the first write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Registered reads on both ports.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_a_r <= mem[rd_addr_a];
      data_b_r <= mem[rd_addr_b];
      vld_a_r  <= valid_r[rd_addr_a];
      vld_b_r  <= valid_r[rd_addr_b];
    end
  end

  assign rd_data_a = vld_a_r ? data_a_r : '0;
  assign rd_data_b = vld_b_r ? data_b_r : '0;

endmodule

`default_nettype wire

### rtl/sbe_issue.sv
// Read issue: resolves stack indexes to slots and picks the read addresses.
// Uses the current stack pointer; depends on sbe_pkg for opcode codes.
`default_nettype none

module sbe_issue #(
  parameter int STACK_DEPTH = 64,
  parameter int SPW         = 7,
  parameter int AW          = 6
) (
  input  wire sbe_pkg::opcode_t   op,
  input  wire logic signed [7:0]  index_a,
  input  wire logic signed [7:0]  index_b,
  input  wire logic [7:0]         drop_count,
  input  wire logic [SPW-1:0]     sp,
  output logic [AW-1:0]           rd_addr_a,
  output logic [AW-1:0]           rd_addr_b,
  output logic [AW-1:0]           slot_ia,
  output sbe_pkg::slot_flags_t    flags
);

  localparam int XW = ((SPW > 8) ? SPW : 8) + 2;
  localparam logic signed [XW-1:0] DEPTH_X = XW'(STACK_DEPTH);

  logic signed [XW-1:0] sp_x;
  logic signed [XW-1:0] ia_x;
  logic signed [XW-1:0] ib_x;
  logic signed [XW-1:0] pa;
  logic signed [XW-1:0] pb;
  logic signed [XW-1:0] p_drop;
  logic signed [XW-1:0] p_m1;
  logic signed [XW-1:0] p_m2;

  assign sp_x = $signed({{(XW-SPW){1'b0}}, sp});
  assign ia_x = $signed({{(XW-8){index_a[7]}}, index_a});
  assign ib_x = $signed({{(XW-8){index_b[7]}}, index_b});

  // Negative indexes count down from the top, others are absolute slots.
  assign pa = index_a[7] ? (sp_x + ia_x) : ia_x;
  assign pb = index_b[7] ? (sp_x + ib_x) : ib_x;

  assign flags.ia_ok = (pa >= 0) && (pa < DEPTH_X);
  assign flags.ib_ok = (pb >= 0) && (pb < DEPTH_X);
  assign slot_ia     = pa[AW-1:0];

  // Slots below the pointer used by pop, return, far return and loop.
  assign p_drop = sp_x - $signed({{(XW-8){1'b0}}, drop_count});
  assign p_m1   = sp_x - XW'(1);
  assign p_m2   = sp_x - XW'(2);

  // Address selection per opcode.
  always_comb begin
    rd_addr_a = pa[AW-1:0];
    rd_addr_b = pb[AW-1:0];
    case (op)
      sbe_pkg::OP_POP:      rd_addr_a = p_drop[AW-1:0];
      sbe_pkg::OP_RET,
      sbe_pkg::OP_LOOP_REL,
      sbe_pkg::OP_LOOP:     rd_addr_a = p_m1[AW-1:0];
      sbe_pkg::OP_RET_FAR: begin
        rd_addr_a = p_m2[AW-1:0];
        rd_addr_b = p_m1[AW-1:0];
      end
      sbe_pkg::OP_SET:      rd_addr_a = pb[AW-1:0];
      default:              rd_addr_a = pa[AW-1:0];
    endcase
  end

endmodule

`default_nettype wire

### rtl/sbe_exec.sv
// Execute unit: next program context, stack pointer, status and stack writes
// for one instruction, from the stored operands and the stack read data.
// Depends on sbe_pkg for opcodes, compare modes and status structs.
`default_nettype none

module sbe_exec #(
  parameter int STACK_DEPTH = 64,
  parameter int SPW         = 7,
  parameter int AW          = 6
) (
  input  wire sbe_pkg::opcode_t            op,
  input  wire logic [15:0]                 immediate,
  input  wire logic [15:0]                 target_address,
  input  wire logic signed [7:0]           offset,
  input  wire logic [2:0]                  compare_mode,
  input  wire logic [7:0]                  drop_count,
  input  wire logic [7:0]                  bank_value,
  input  wire logic [15:0]                 time_now,
  input  wire logic [AW-1:0]               slot_ia,
  input  wire sbe_pkg::slot_flags_t        flags,
  input  wire logic [15:0]                 rd_a,
  input  wire logic [15:0]                 rd_b,
  input  wire sbe_pkg::ctx_t               ctx,
  input  wire logic [SPW-1:0]              sp,
  output sbe_pkg::ctx_t                    ctx_nxt,
  output logic [SPW-1:0]                   sp_nxt,
  output sbe_pkg::status_t                 status,
  output logic                             wr_en,
  output logic [AW-1:0]                    wr_addr,
  output logic [15:0]                      wr_data,
  output logic                             wr2_en,
  output logic [AW-1:0]                    wr2_addr,
  output logic [15:0]                      wr2_data
);

  localparam int XW = ((SPW > 8) ? SPW : 8) + 2;
  localparam logic signed [XW-1:0] DEPTH_X  = XW'(STACK_DEPTH);
  localparam logic [SPW-1:0]       DEPTH_SP = SPW'(STACK_DEPTH);

  logic signed [XW-1:0] sp_x;
  logic signed [XW-1:0] sp_w;
  logic signed [XW-1:0] n_drop;
  logic signed [XW-1:0] n_res;
  logic [SPW-1:0]       sp_m1;
  logic [SPW-1:0]       sp_p1;
  logic [15:0]          pc_adv;
  logic [15:0]          pc_rel;
  logic [15:0]          val_a;
  logic [15:0]          val_set;
  logic [15:0]          val_b;
  logic signed [15:0]   cmp_a;
  logic signed [15:0]   cmp_b;
  logic                 cmp_res;
  logic                 op_unknown;
  logic [1:0]           n_push;
  logic [15:0]          push_d1;
  logic [15:0]          push_d2;
  logic                 flt;
  logic [15:0]          pop_word;

  assign sp_x   = $signed({{(XW-SPW){1'b0}}, sp});
  assign n_drop = sp_x - $signed({{(XW-8){1'b0}}, drop_count});
  assign n_res  = sp_x + $signed({{(XW-8){offset[7]}}, offset});
  assign sp_m1  = sp - SPW'(1);
  assign sp_p1  = sp + SPW'(1);

  // The program counter advances past the opcode and its arguments first.
  assign pc_adv = ctx.pc + 16'd1 + {13'd0, sbe_pkg::arg_len(op)};
  assign pc_rel = pc_adv + {{8{offset[7]}}, offset};

  // Out-of-bounds index reads give zero.
  assign val_a   = flags.ia_ok ? rd_a : '0;
  assign val_b   = flags.ib_ok ? rd_b : '0;
  assign val_set = flags.ib_ok ? rd_a : '0;

  // Signed compare of the conditional branch.
  assign cmp_a = $signed(val_a);
  assign cmp_b = $signed(val_b);
  always_comb begin
    case (compare_mode)
      sbe_pkg::CMP_EQ: cmp_res = (cmp_a == cmp_b);
      sbe_pkg::CMP_LT: cmp_res = (cmp_a < cmp_b);
      sbe_pkg::CMP_GT: cmp_res = (cmp_a > cmp_b);
      sbe_pkg::CMP_LE: cmp_res = (cmp_a <= cmp_b);
      sbe_pkg::CMP_GE: cmp_res = (cmp_a >= cmp_b);
      default:         cmp_res = 1'b0;
    endcase
  end

  assign op_unknown = (op > sbe_pkg::OP_START);

  // Instruction handlers.
  always_comb begin
    ctx_nxt  = ctx;
    sp_w     = sp_x;
    flt      = 1'b0;
    pop_word = '0;
    n_push   = 2'd0;
    push_d1  = '0;
    push_d2  = '0;
    wr_en    = 1'b0;
    wr_addr  = slot_ia;
    wr_data  = '0;
    wr2_en   = 1'b0;
    wr2_addr = sp_p1[AW-1:0];
    wr2_data = '0;

    if (op == sbe_pkg::OP_START) begin
      ctx_nxt.pc   = target_address;
      ctx_nxt.bank = bank_value;
      ctx_nxt.run  = 1'b1;
      sp_w         = '0;
    end else if (op == sbe_pkg::OP_END || op_unknown) begin
      ctx_nxt.run = 1'b0;
    end else if (ctx.run) begin
      ctx_nxt.pc = pc_adv;
      case (op)
        sbe_pkg::OP_PUSH: begin
          n_push  = 2'd1;
          push_d1 = immediate;
        end
        sbe_pkg::OP_POP: begin
          if (n_drop < 0) begin
            flt  = 1'b1;
            sp_w = '0;
          end else begin
            sp_w = n_drop;
            if (n_drop < DEPTH_X) begin
              pop_word = rd_a;
            end else begin
              flt = 1'b1;
            end
          end
        end
        sbe_pkg::OP_CALL_REL: begin
          n_push     = 2'd1;
          push_d1    = pc_adv;
          ctx_nxt.pc = pc_rel;
        end
        sbe_pkg::OP_CALL: begin
          n_push     = 2'd1;
          push_d1    = pc_adv;
          ctx_nxt.pc = target_address;
        end
        sbe_pkg::OP_RET: begin
          if (sp == '0) begin
            flt = 1'b1;
          end else begin
            sp_w       = sp_x - XW'(1);
            ctx_nxt.pc = rd_a;
          end
        end
        sbe_pkg::OP_LOOP_REL,
        sbe_pkg::OP_LOOP: begin
          if (sp == '0) begin
            flt = 1'b1;
          end else if (rd_a != '0) begin
            wr_en      = 1'b1;
            wr_addr    = sp_m1[AW-1:0];
            wr_data    = rd_a - 16'd1;
            ctx_nxt.pc = (op == sbe_pkg::OP_LOOP_REL) ? pc_rel : target_address;
          end else begin
            sp_w = sp_x - XW'(1);
          end
        end
        sbe_pkg::OP_JUMP_REL: ctx_nxt.pc = pc_rel;
        sbe_pkg::OP_JUMP:     ctx_nxt.pc = target_address;
        sbe_pkg::OP_CALL_FAR: begin
          n_push       = 2'd2;
          push_d1      = pc_adv;
          push_d2      = {8'd0, ctx.bank};
          ctx_nxt.pc   = target_address;
          ctx_nxt.bank = bank_value;
        end
        sbe_pkg::OP_RET_FAR: begin
          if (sp < SPW'(2)) begin
            flt  = 1'b1;
            sp_w = '0;
          end else begin
            sp_w         = sp_x - XW'(2);
            ctx_nxt.bank = rd_b[7:0];
            ctx_nxt.pc   = rd_a;
          end
        end
        sbe_pkg::OP_SYSTIME: begin
          n_push  = 2'd1;
          push_d1 = time_now;
        end
        sbe_pkg::OP_IFCOND: begin
          flt = !flags.ia_ok || !flags.ib_ok;
          if (cmp_res) begin
            ctx_nxt.pc = target_address;
          end
          if (n_drop < 0) begin
            flt  = 1'b1;
            sp_w = '0;
          end else begin
            sp_w = n_drop;
          end
        end
        sbe_pkg::OP_PUSH_VALUE: begin
          flt     = !flags.ia_ok;
          n_push  = 2'd1;
          push_d1 = val_a;
        end
        sbe_pkg::OP_RESERVE: begin
          if (n_res < 0) begin
            flt  = 1'b1;
            sp_w = '0;
          end else if (n_res > DEPTH_X) begin
            flt  = 1'b1;
            sp_w = DEPTH_X;
          end else begin
            sp_w = n_res;
          end
        end
        sbe_pkg::OP_SET: begin
          flt     = !flags.ia_ok || !flags.ib_ok;
          wr_en   = flags.ia_ok;
          wr_data = val_set;
        end
        sbe_pkg::OP_SET_CONST: begin
          flt     = !flags.ia_ok;
          wr_en   = flags.ia_ok;
          wr_data = immediate;
        end
        default: begin
          // Invoke, thread start and debug print only advance the counter.
        end
      endcase

      // Shared push path: the first word goes out now, a second one in the next cycle.
      if (n_push != 2'd0) begin
        if (sp == DEPTH_SP) begin
          flt  = 1'b1;
          sp_w = DEPTH_X;
        end else begin
          wr_en   = 1'b1;
          wr_addr = sp[AW-1:0];
          wr_data = push_d1;
          sp_w    = sp_x + XW'(1);
          if (n_push == 2'd2) begin
            if (sp_p1 == DEPTH_SP) begin
              flt = 1'b1;
            end else begin
              wr2_en   = 1'b1;
              wr2_data = push_d2;
              sp_w     = sp_x + XW'(2);
            end
          end
        end
      end
    end
  end

  assign sp_nxt        = sp_w[SPW-1:0];
  assign status.fault  = flt;
  assign status.popped = pop_word;

endmodule

`default_nettype wire

### rtl/sbe_port_checker.sv
// Port-level checks of the stack bytecode executor, bound to its top level.
// Sees only the top-level ports; depends on stack_bytecode_executor.
`default_nettype none

module sbe_port_checker #(
  parameter int STACK_DEPTH = 64
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [15:0]                       out_program_counter,
  input wire logic [7:0]                        out_code_bank,
  input wire logic [$clog2(STACK_DEPTH+1)-1:0]  out_stack_level,
  input wire logic [15:0]                       out_popped_word,
  input wire logic                              out_running,
  input wire logic                              out_fault
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);

  // The reported pointer never passes the stack depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_stack_level <= SPW'(STACK_DEPTH)))
  else $error("stack level beyond stack depth");

  // A stopped machine never reports a fault.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_running) |-> !out_fault)
  else $error("fault reported while not running");

  // A nonzero popped word only comes from a clean pop of a running script.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_popped_word != 16'd0)) |-> (out_running && !out_fault))
  else $error("popped word without a clean pop");

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_program_counter)
      && $stable(out_code_bank) && $stable(out_stack_level)
      && $stable(out_popped_word) && $stable(out_running) && $stable(out_fault)))
  else $error("stalled result word changed");

  // Reset empties the result register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
  else $error("result valid right after reset");

endmodule

bind stack_bytecode_executor sbe_port_checker #(
  .STACK_DEPTH(STACK_DEPTH)
) u_port_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_program_counter(out_program_counter),
  .out_code_bank      (out_code_bank),
  .out_stack_level    (out_stack_level),
  .out_popped_word    (out_popped_word),
  .out_running        (out_running),
  .out_fault          (out_fault)
);

`default_nettype wire
